FILE: sv/mngt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mngt_pkg
// Shared types and constants of the note gate tracker: message codes, the
// per-item operation, the note memory entry layout and the scan result.
// ----------------------------------------------------------------------------
package mngt_pkg;

  localparam int ORDER_WIDTH_DEF = 32;

  localparam int NOTE_ENTRIES = 2048;
  localparam int NOTE_IDX_W   = 11;
  localparam int CH_W         = 4;
  localparam int KEY_W        = 7;
  localparam int VEL_W        = 7;
  localparam int HELD_W       = 8;

  // entry layout from bit 0: held count, sustained flag, velocity, stamp
  localparam int ENTRY_SUS_BIT = HELD_W;
  localparam int ENTRY_VEL_LSB = HELD_W + 1;
  localparam int ENTRY_FIXED_W = HELD_W + 1 + VEL_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CTRL     = 4'hb;

  localparam logic [KEY_W-1:0] CC_SUSTAIN    = 7'd64;
  localparam logic [KEY_W-1:0] CC_SOUND_OFF  = 7'd120;
  localparam logic [KEY_W-1:0] CC_RESET_CTRL = 7'd121;
  localparam logic [KEY_W-1:0] CC_NOTES_OFF  = 7'd123;

  localparam logic [HELD_W-1:0] HELD_MAX  = 8'd255;
  localparam logic [KEY_W-1:0]  IDLE_KEY  = 7'd60;
  localparam logic [VEL_W-1:0]  IDLE_VEL  = 7'd127;
  localparam logic [7:0]        PITCH_REF = 8'd60;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_SUS_CLR,
    OP_ALL_OFF,
    OP_NOTES_OFF,
    OP_PANIC
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [CH_W-1:0]    ch;
    logic [KEY_W-1:0]   key;
    logic [VEL_W-1:0]   vel;
    logic               pedal;
  } op_t;

  typedef struct packed {
    logic                  vld;
    logic [NOTE_IDX_W-1:0] idx;
  } sweep_t;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] key;
    logic [VEL_W-1:0] vel;
  } best_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: sv/midi_note_gate_tracker_core.sv
`default_nettype none
// the input takes no new transaction until the previous one has swept the 2048-entry
// note memory, one entry a cycle through the shared update and compare unit, and
// its result has been loaded into the output register
// a finished result may wait in the output register while the next item runs
// reset: synchronous; a clearing pass zeroes the note memory
//   with in_tready low; pedals, order counter and pitch enable reset to zero
// ----------------------------------------------------------------------------
// midi_note_gate_tracker_core
// Last-note priority gate tracker with sustain pedal for 16 MIDI channels.
// ----------------------------------------------------------------------------
module midi_note_gate_tracker_core #(
  parameter int ORDER_WIDTH = mngt_pkg::ORDER_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // msg_port[15:0], status_byte[23:16], data_one[31:24], data_two[39:32]
  input  wire logic [mngt_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode[0]
  input  wire logic                              in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // gate[0], newest_key[7:1], newest_velocity[14:8], pitch_offset[22:15],
  // reset_engine[23]
  output logic      [mngt_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // midi_pitch_enable[0]
  input  wire logic                              cfg_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready
);

  localparam int DATA_W = mngt_pkg::ENTRY_FIXED_W + ORDER_WIDTH;

  logic                              res_load, res_ready, eng, start, rd_en;
  logic [mngt_pkg::NOTE_IDX_W-1:0]   rd_addr, wr_addr;
  logic [DATA_W-1:0]                 rd_data, wr_data;
  logic                              wr_en;
  logic [ORDER_WIDTH-1:0]            op_stamp;
  mngt_pkg::sweep_t                  sweep;
  mngt_pkg::op_t                     op;
  mngt_pkg::best_t                   best;

  logic                              pitch_en_r, pitch_en_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [mngt_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [mngt_pkg::KEY_W-1:0]        res_key;
  logic [mngt_pkg::VEL_W-1:0]        res_vel;
  logic [7:0]                        res_pitch;

  mngt_ctrl #(
    .ORDER_WIDTH (ORDER_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .res_load  (res_load),
    .res_ready (res_ready),
    .eng       (eng),
    .start     (start),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .sweep     (sweep),
    .op        (op),
    .op_stamp  (op_stamp)
  );

  mngt_note_ram #(
    .DATA_W (DATA_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mngt_scan_unit #(
    .ORDER_WIDTH (ORDER_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .op       (op),
    .op_stamp (op_stamp),
    .sweep    (sweep),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .best     (best)
  );

  assign cfg_ready    = 1'b1;
  assign pitch_en_nxt = (cfg_valid && cfg_ready) ? cfg_data : pitch_en_r;

  assign res_key   = best.found ? best.key : mngt_pkg::IDLE_KEY;
  assign res_vel   = best.found ? best.vel : mngt_pkg::IDLE_VEL;
  assign res_pitch = (best.found && pitch_en_r) ? ({1'b0, res_key} - mngt_pkg::PITCH_REF)
                                                : 8'd0;

  // output register frees the sequencer once the result is parked
  assign res_load = res_ready && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {eng, res_pitch, res_vel, res_key, best.found};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_en_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pitch_en_r  <= pitch_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an accepted transaction starts a sweep, so the input closes at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again right after a transaction");

  // no active note reports the idle key and velocity and no pitch
  a_idle_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |->
      out_tdata[7:1] == mngt_pkg::IDLE_KEY && out_tdata[14:8] == mngt_pkg::IDLE_VEL &&
      out_tdata[22:15] == 8'd0)
    else $error("idle report carries note data");

  // a result is only loaded when the sequencer has finished a sweep
  a_load_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !rd_en && !sweep.vld && !in_tready)
    else $error("result loaded while the sweep is running");

endmodule
`default_nettype wire

FILE: sv/mngt_note_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mngt_note_ram
// Note table memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mngt_note_ram #(
  parameter int DATA_W = mngt_pkg::ENTRY_FIXED_W + mngt_pkg::ORDER_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rd_en,
  input  wire logic [mngt_pkg::NOTE_IDX_W-1:0]   rd_addr,
  output logic      [DATA_W-1:0]                 rd_data,
  input  wire logic                              wr_en,
  input  wire logic [mngt_pkg::NOTE_IDX_W-1:0]   wr_addr,
  input  wire logic [DATA_W-1:0]                 wr_data
);

  logic [DATA_W-1:0] mem_r [mngt_pkg::NOTE_ENTRIES];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: sv/mngt_scan_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mngt_scan_unit
// Shared entry unit: applies the current operation to one note entry per
// cycle, writes it back and keeps the newest active note seen so far.
// ----------------------------------------------------------------------------
module mngt_scan_unit #(
  parameter int ORDER_WIDTH = mngt_pkg::ORDER_WIDTH_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         start,
  input  wire mngt_pkg::op_t                                op,
  input  wire logic [ORDER_WIDTH-1:0]                       op_stamp,
  input  wire mngt_pkg::sweep_t                             sweep,
  input  wire logic [mngt_pkg::ENTRY_FIXED_W+ORDER_WIDTH-1:0] rd_data,
  output logic                                              wr_en,
  output logic      [mngt_pkg::NOTE_IDX_W-1:0]              wr_addr,
  output logic      [mngt_pkg::ENTRY_FIXED_W+ORDER_WIDTH-1:0] wr_data,
  output mngt_pkg::best_t                                   best
);

  logic [mngt_pkg::HELD_W-1:0] held, held_n;
  logic                        sus, sus_n;
  logic [mngt_pkg::VEL_W-1:0]  vel, vel_n;
  logic [ORDER_WIDTH-1:0]      stamp, stamp_n;
  logic                        hit, in_ch, active_n, newer;

  logic                        found_r, found_nxt;
  logic [ORDER_WIDTH-1:0]      best_stamp_r, best_stamp_nxt;
  logic [mngt_pkg::KEY_W-1:0]  best_key_r, best_key_nxt;
  logic [mngt_pkg::VEL_W-1:0]  best_vel_r, best_vel_nxt;

  assign held  = rd_data[mngt_pkg::HELD_W-1:0];
  assign sus   = rd_data[mngt_pkg::ENTRY_SUS_BIT];
  assign vel   = rd_data[mngt_pkg::ENTRY_VEL_LSB +: mngt_pkg::VEL_W];
  assign stamp = rd_data[mngt_pkg::ENTRY_FIXED_W +: ORDER_WIDTH];

  assign hit   = (sweep.idx == {op.ch, op.key});
  assign in_ch = (sweep.idx[mngt_pkg::NOTE_IDX_W-1 -: mngt_pkg::CH_W] == op.ch);

  always_comb begin
    held_n  = held;
    sus_n   = sus;
    vel_n   = vel;
    stamp_n = stamp;
    case (op.kind)
      mngt_pkg::OP_NOTE_ON: begin
        if (hit) begin
          if (held != mngt_pkg::HELD_MAX) begin
            held_n = held + 8'd1;
          end
          sus_n   = 1'b0;
          vel_n   = op.vel;
          stamp_n = op_stamp;
        end
      end
      mngt_pkg::OP_NOTE_OFF: begin
        if (hit && (held != '0)) begin
          held_n = held - 8'd1;
          // last release of the key hands it to the pedal
          if (held == 8'd1) begin
            sus_n = op.pedal;
          end
        end
      end
      mngt_pkg::OP_SUS_CLR: begin
        if (in_ch) begin
          sus_n = 1'b0;
        end
      end
      mngt_pkg::OP_ALL_OFF: begin
        if (in_ch) begin
          held_n = '0;
          sus_n  = 1'b0;
        end
      end
      mngt_pkg::OP_NOTES_OFF: begin
        if (in_ch) begin
          held_n = '0;
          sus_n  = op.pedal && ((held != '0) || sus);
        end
      end
      mngt_pkg::OP_PANIC: begin
        held_n  = '0;
        sus_n   = 1'b0;
        vel_n   = '0;
        stamp_n = '0;
      end
      default: begin
      end
    endcase
  end

  assign active_n = (held_n != '0) || sus_n;
  // strict compare keeps the lowest index on equal stamps
  assign newer    = !found_r || (stamp_n > best_stamp_r);

  assign wr_en   = sweep.vld;
  assign wr_addr = sweep.idx;
  assign wr_data = {stamp_n, vel_n, sus_n, held_n};

  always_comb begin
    found_nxt      = found_r;
    best_stamp_nxt = best_stamp_r;
    best_key_nxt   = best_key_r;
    best_vel_nxt   = best_vel_r;
    if (start) begin
      found_nxt = 1'b0;
    end else if (sweep.vld && active_n && newer) begin
      found_nxt      = 1'b1;
      best_stamp_nxt = stamp_n;
      best_key_nxt   = sweep.idx[mngt_pkg::KEY_W-1:0];
      best_vel_nxt   = vel_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_stamp_r <= best_stamp_nxt;
    best_key_r   <= best_key_nxt;
    best_vel_r   <= best_vel_nxt;
  end

  assign best.found = found_r;
  assign best.key   = best_key_r;
  assign best.vel   = best_vel_r;

endmodule
`default_nettype wire

FILE: sv/mngt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mngt_ctrl
// Sequencer: decodes an accepted message, keeps pedal bits and the order
// counter, and steps the sweep address over the whole note table.
// ----------------------------------------------------------------------------
module mngt_ctrl #(
  parameter int ORDER_WIDTH = mngt_pkg::ORDER_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [mngt_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                               in_tuser,
  input  wire logic                               res_load,
  output logic                                    res_ready,
  output logic                                    eng,
  output logic                                    start,
  output logic                                    rd_en,
  output logic      [mngt_pkg::NOTE_IDX_W-1:0]    rd_addr,
  output mngt_pkg::sweep_t                        sweep,
  output mngt_pkg::op_t                           op,
  output logic      [ORDER_WIDTH-1:0]             op_stamp
);

  mngt_pkg::state_t                  state_r, state_nxt;
  logic [mngt_pkg::NOTE_IDX_W-1:0]   addr_r, addr_nxt;
  logic                              init_r, init_nxt;
  mngt_pkg::op_t                     op_r, op_nxt;
  logic [ORDER_WIDTH-1:0]            stamp_r, stamp_nxt;
  logic [ORDER_WIDTH-1:0]            cnt_r, cnt_nxt;
  logic [15:0]                       pedal_r, pedal_nxt;
  logic                              eng_r, eng_nxt;
  mngt_pkg::sweep_t                  sweep_r, sweep_nxt;

  logic [15:0]                       port;
  logic [7:0]                        status;
  logic [mngt_pkg::KEY_W-1:0]        key;
  logic [mngt_pkg::VEL_W-1:0]        value;
  logic [mngt_pkg::CH_W-1:0]         ch;
  logic                              accept;

  mngt_pkg::op_t                     dec_op;
  logic [15:0]                       dec_pedal;
  logic                              dec_eng;
  logic                              dec_note_on;

  assign port   = in_tdata[15:0];
  assign status = in_tdata[23:16];
  assign key    = in_tdata[30:24];
  assign value  = in_tdata[38:32];
  assign ch     = status[3:0];

  assign in_tready = (state_r == mngt_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // message decode
  always_comb begin
    dec_op.kind  = mngt_pkg::OP_NONE;
    dec_op.ch    = ch;
    dec_op.key   = key;
    dec_op.vel   = value;
    dec_op.pedal = pedal_r[ch];
    dec_pedal    = pedal_r;
    dec_eng      = 1'b0;
    dec_note_on  = 1'b0;
    if (in_tuser) begin
      dec_op.kind = mngt_pkg::OP_PANIC;
      dec_pedal   = '0;
      dec_eng     = 1'b1;
    end else if (port == '0) begin
      case (status[7:4])
        mngt_pkg::TYPE_NOTE_ON: begin
          if (value != '0) begin
            dec_op.kind = mngt_pkg::OP_NOTE_ON;
            dec_note_on = 1'b1;
          end else begin
            dec_op.kind = mngt_pkg::OP_NOTE_OFF;
          end
        end
        mngt_pkg::TYPE_NOTE_OFF: begin
          dec_op.kind = mngt_pkg::OP_NOTE_OFF;
        end
        mngt_pkg::TYPE_CTRL: begin
          case (key)
            mngt_pkg::CC_SUSTAIN: begin
              dec_pedal[ch] = value[6];
              if (!value[6]) begin
                dec_op.kind = mngt_pkg::OP_SUS_CLR;
              end
            end
            mngt_pkg::CC_SOUND_OFF: begin
              dec_op.kind   = mngt_pkg::OP_ALL_OFF;
              dec_pedal[ch] = 1'b0;
              dec_eng       = 1'b1;
            end
            mngt_pkg::CC_RESET_CTRL: begin
              dec_op.kind   = mngt_pkg::OP_SUS_CLR;
              dec_pedal[ch] = 1'b0;
            end
            mngt_pkg::CC_NOTES_OFF: begin
              dec_op.kind = mngt_pkg::OP_NOTES_OFF;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    init_nxt  = init_r;
    op_nxt    = op_r;
    stamp_nxt = stamp_r;
    cnt_nxt   = cnt_r;
    pedal_nxt = pedal_r;
    eng_nxt   = eng_r;
    case (state_r)
      mngt_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt    = dec_op;
          pedal_nxt = dec_pedal;
          eng_nxt   = dec_eng;
          stamp_nxt = cnt_r + ORDER_WIDTH'(1);
          if (dec_note_on) begin
            cnt_nxt = cnt_r + ORDER_WIDTH'(1);
          end
          addr_nxt  = '0;
          state_nxt = mngt_pkg::ST_SWEEP;
        end
      end
      mngt_pkg::ST_SWEEP: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == '1) begin
          state_nxt = mngt_pkg::ST_DRAIN;
        end
      end
      mngt_pkg::ST_DRAIN: begin
        // the clearing pass after reset has no result
        init_nxt  = 1'b0;
        state_nxt = init_r ? mngt_pkg::ST_IDLE : mngt_pkg::ST_DONE;
      end
      mngt_pkg::ST_DONE: begin
        if (res_load) begin
          state_nxt = mngt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mngt_pkg::ST_IDLE;
      end
    endcase
  end

  assign rd_en         = (state_r == mngt_pkg::ST_SWEEP);
  assign rd_addr       = addr_r;
  assign sweep_nxt.vld = rd_en;
  assign sweep_nxt.idx = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mngt_pkg::ST_SWEEP;
      addr_r       <= '0;
      init_r       <= 1'b1;
      op_r.kind    <= mngt_pkg::OP_PANIC;
      op_r.ch      <= '0;
      op_r.key     <= '0;
      op_r.vel     <= '0;
      op_r.pedal   <= 1'b0;
      cnt_r        <= '0;
      pedal_r      <= '0;
      eng_r        <= 1'b0;
      sweep_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      init_r       <= init_nxt;
      op_r         <= op_nxt;
      cnt_r        <= cnt_nxt;
      pedal_r      <= pedal_nxt;
      eng_r        <= eng_nxt;
      sweep_r      <= sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r <= stamp_nxt;
  end

  assign start     = accept;
  assign res_ready = (state_r == mngt_pkg::ST_DONE);
  assign eng       = eng_r;
  assign sweep     = sweep_r;
  assign op        = op_r;
  assign op_stamp  = stamp_r;

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the note gate tracker core. A directed table covers
// the note, pedal and controller corners, then random MIDI traffic runs in
// three handshake regimes. Every report is compared field by field with the
// table's expected report or a behavioural model of the note table in the bench.
// ----------------------------------------------------------------------------
module tb;
  import mngt_pkg::*;

  localparam int ORDER_W     = ORDER_WIDTH_DEF;
  localparam int DIR_ROWS    = 26;
  localparam int HOLD_CYCLES = 9000;
  localparam int STALL_LIMIT = 30000;
  localparam int TAIL_CYCLES = 2100;

  localparam logic OPC_MIDI  = 1'b0;
  localparam logic OPC_PANIC = 1'b1;

  localparam logic [3:0]       TYPE_BEND    = 4'he;
  localparam logic [KEY_W-1:0] CC_VOLUME    = 7'd7;
  localparam logic [VEL_W-1:0] PEDAL_ON_MIN = 7'd64;

  // channel and key pools that keep random notes colliding
  localparam logic [15:0] CH_POOL  = {4'd15, 4'd9, 4'd1, 4'd0};
  localparam logic [55:0] KEY_POOL = {7'd127, 7'd126, 7'd64, 7'd61,
                                      7'd60, 7'd59, 7'd1, 7'd0};

  typedef struct packed {
    logic       op;
    logic [15:0] port;
    logic [7:0] status;
    logic [7:0] d1;
    logic [7:0] d2;
  } midi_item_t;

  // same layout as out_tdata
  typedef struct packed {
    logic             eng;
    logic [7:0]       pitch;
    logic [VEL_W-1:0] vel;
    logic [KEY_W-1:0] key;
    logic             gate;
  } gate_report_t;

  typedef struct packed {
    logic         has_want;
    gate_report_t want;
    midi_item_t   it;
  } dir_row_t;

  localparam gate_report_t REP_NONE   = '0;
  localparam gate_report_t REP_IDLE   = {1'b0, 8'h00, IDLE_VEL, IDLE_KEY, 1'b0};
  localparam gate_report_t REP_ENGINE = {1'b1, 8'h00, IDLE_VEL, IDLE_KEY, 1'b0};
  localparam gate_report_t REP_LOW    = {1'b0, 8'hc4, 7'd1, 7'd0, 1'b1};
  localparam gate_report_t REP_HIGH   = {1'b0, 8'h43, 7'd127, 7'd127, 1'b1};

  dir_row_t dir_table [DIR_ROWS] = '{
    {1'b1, REP_IDLE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_OFF, 4'h0}, 8'd5,   8'd0},
    {1'b1, REP_LOW,    OPC_MIDI,  16'h0000, {TYPE_NOTE_ON, 4'h0},  8'd0,   8'd1},
    {1'b1, REP_HIGH,   OPC_MIDI,  16'h0000, {TYPE_NOTE_ON, 4'hf},  8'h7f,  8'h7f},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_ON, 4'hf},  8'hff,  8'hff},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_ON, 4'hf},  8'hff,  8'h80},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_OFF, 4'hf}, 8'h7f,  8'h40},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_CTRL, 4'h0}, {1'b0, CC_SUSTAIN}, 8'd64},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_OFF, 4'h0}, 8'd0,   8'd0},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_ON, 4'h3},  8'd64,  8'd100},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_OFF, 4'h3}, 8'd64,  8'd0},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_CTRL, 4'h0}, {1'b0, CC_NOTES_OFF}, 8'd0},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_CTRL, 4'h0}, {1'b0, CC_SUSTAIN}, 8'd63},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_ON, 4'h0},  8'd10,  8'd90},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_ON, 4'h1},  8'd20,  8'd70},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_CTRL, 4'h1}, {1'b0, CC_SUSTAIN}, 8'hff},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_OFF, 4'h1}, 8'd20,  8'd0},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_CTRL, 4'h1}, {1'b0, CC_RESET_CTRL}, 8'd0},
    {1'b0, REP_NONE,   OPC_MIDI,  16'hffff, {TYPE_NOTE_ON, 4'h0},  8'd30,  8'd50},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0001, {TYPE_CTRL, 4'h0}, {1'b0, CC_SOUND_OFF}, 8'd0},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_BEND, 4'h0},     8'd0,   8'h40},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_CTRL, 4'h0}, {1'b0, CC_VOLUME}, 8'd100},
    {1'b1, REP_ENGINE, OPC_MIDI,  16'h0000, {TYPE_CTRL, 4'h0}, {1'b0, CC_SOUND_OFF}, 8'd0},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_ON, 4'h2},  8'd40,  8'd127},
    {1'b1, REP_ENGINE, OPC_PANIC, 16'hffff, 8'hff,                 8'hff,  8'hff},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_NOTE_ON, 4'h2},  8'd40,  8'd1},
    {1'b0, REP_NONE,   OPC_MIDI,  16'h0000, {TYPE_CTRL, 4'h2}, {1'b0, CC_NOTES_OFF}, 8'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_data = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;

  // bench copy of the note table
  logic [HELD_W-1:0]  note_held  [NOTE_ENTRIES];
  logic               note_sus   [NOTE_ENTRIES];
  logic [ORDER_W-1:0] note_stamp [NOTE_ENTRIES];
  logic [VEL_W-1:0]   note_vel   [NOTE_ENTRIES];
  logic               chan_pedal [16];
  logic [ORDER_W-1:0] note_order;
  logic               pitch_en;

  gate_report_t gate_q [$];

  int err_count    = 0;
  int tx_idle_pct  = 38;
  int rx_idle_pct  = 47;
  int rx_hold_req  = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int stall_cycles = 0;

  midi_note_gate_tracker_core #(
    .ORDER_WIDTH(ORDER_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic void clear_note_table();
    for (int i = 0; i < NOTE_ENTRIES; i++) begin
      note_held[i]  = '0;
      note_sus[i]   = 1'b0;
      note_stamp[i] = '0;
      note_vel[i]   = '0;
    end
    for (int c = 0; c < 16; c++) chan_pedal[c] = 1'b0;
  endfunction

  // applies one message to the table and scans for the newest sounding note
  function automatic gate_report_t predict_gate(input midi_item_t it);
    logic [3:0]            msg_type;
    logic [CH_W-1:0]       ch;
    logic [KEY_W-1:0]      key;
    logic [VEL_W-1:0]      val;
    int                    idx;
    int                    base;
    int                    best;
    logic                  sounding;
    logic                  found;
    gate_report_t          rep;
    rep      = '0;
    found    = 1'b0;
    best     = 0;
    msg_type = it.status[7:4];
    ch       = it.status[3:0];
    key      = it.d1[KEY_W-1:0];
    val      = it.d2[VEL_W-1:0];
    base     = ch * 128;
    idx      = base + key;
    if (it.op == OPC_PANIC) begin
      clear_note_table();
      rep.eng = 1'b1;
    end else if (it.port == 16'h0000) begin
      if (msg_type == TYPE_NOTE_ON && val != '0) begin
        if (note_held[idx] != HELD_MAX) note_held[idx] = note_held[idx] + 1'b1;
        note_sus[idx]   = 1'b0;
        note_vel[idx]   = val;
        note_order      = note_order + 1'b1;
        note_stamp[idx] = note_order;
      end else if (msg_type == TYPE_NOTE_OFF || msg_type == TYPE_NOTE_ON) begin
        if (note_held[idx] != '0) begin
          note_held[idx] = note_held[idx] - 1'b1;
          if (note_held[idx] == '0) note_sus[idx] = chan_pedal[ch];
        end
      end else if (msg_type == TYPE_CTRL) begin
        if (key == CC_SUSTAIN) begin
          chan_pedal[ch] = (val >= PEDAL_ON_MIN);
          if (!chan_pedal[ch])
            for (int k = 0; k < 128; k++) note_sus[base + k] = 1'b0;
        end else if (key == CC_SOUND_OFF || key == CC_NOTES_OFF) begin
          for (int k = 0; k < 128; k++) begin
            sounding = (note_held[base + k] != '0) || note_sus[base + k];
            note_sus[base + k]  = (key == CC_NOTES_OFF) && chan_pedal[ch] && sounding;
            note_held[base + k] = '0;
          end
          if (key == CC_SOUND_OFF) begin
            chan_pedal[ch] = 1'b0;
            rep.eng        = 1'b1;
          end
        end else if (key == CC_RESET_CTRL) begin
          chan_pedal[ch] = 1'b0;
          for (int k = 0; k < 128; k++) note_sus[base + k] = 1'b0;
        end
      end
    end
    // strict compare keeps the lowest index on equal stamps
    for (int i = 0; i < NOTE_ENTRIES; i++) begin
      if ((note_held[i] != '0 || note_sus[i]) &&
          (!found || note_stamp[i] > note_stamp[best])) begin
        found = 1'b1;
        best  = i;
      end
    end
    rep.gate = found;
    if (found) begin
      rep.key = best[KEY_W-1:0];
      rep.vel = note_vel[best];
      if (pitch_en) rep.pitch = {1'b0, rep.key} - PITCH_REF;
    end else begin
      rep.key = IDLE_KEY;
      rep.vel = IDLE_VEL;
    end
    return rep;
  endfunction

  // mostly well-formed note and pedal traffic on a few channels, plus noise
  function automatic midi_item_t roll_midi_item();
    midi_item_t       it;
    int               pick;
    logic [3:0]       ch;
    logic [KEY_W-1:0] key;
    logic [VEL_W-1:0] vel;
    it.op     = OPC_MIDI;
    it.port   = '0;
    it.status = 8'($urandom);
    it.d1     = 8'($urandom);
    it.d2     = 8'($urandom);
    pick      = $urandom_range(99);
    if (pick < 3) begin
      it.op   = OPC_PANIC;
      it.port = 16'($urandom);
    end else if (pick < 8) begin
      it.port = 16'($urandom_range(65535, 1));
    end else if (pick >= 13) begin
      ch  = ($urandom_range(99) < 75) ? CH_POOL[4*$urandom_range(3) +: 4] : 4'($urandom);
      key = ($urandom_range(99) < 80) ? KEY_POOL[7*$urandom_range(7) +: 7] : 7'($urandom);
      vel = 7'($urandom_range(127, 1));
      it.d1 = {it.d1[7], key};
      pick  = $urandom_range(99);
      if (pick < 42) begin
        it.status = {TYPE_NOTE_ON, ch};
        it.d2     = {it.d2[7], vel};
      end else if (pick < 62) begin
        it.status = {TYPE_NOTE_OFF, ch};
      end else if (pick < 70) begin
        // note on with zero velocity acts as note off
        it.status = {TYPE_NOTE_ON, ch};
        it.d2     = {it.d2[7], 7'd0};
      end else begin
        it.status = {TYPE_CTRL, ch};
        if (pick < 84)      it.d1 = {it.d1[7], CC_SUSTAIN};
        else if (pick < 89) it.d1 = {it.d1[7], CC_NOTES_OFF};
        else if (pick < 93) it.d1 = {it.d1[7], CC_SOUND_OFF};
        else if (pick < 97) it.d1 = {it.d1[7], CC_RESET_CTRL};
      end
    end
    return it;
  endfunction

  task automatic send_item(input midi_item_t it, input logic has_want,
                           input gate_report_t want);
    gate_report_t rep;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {it.d2, it.d1, it.status, it.port};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rep = predict_gate(it);
    gate_q.insert(gate_q.size(), has_want ? want : rep);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (gate_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_pitch_en(input logic en);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pitch_en   = en;
  endtask

  // ignored-port items do not count towards the phase total
  task automatic run_random(input int n_items);
    midi_item_t it;
    int         counted;
    counted = 0;
    while (counted < n_items) begin
      it = roll_midi_item();
      send_item(it, 1'b0, REP_NONE);
      if (!(it.op == OPC_MIDI && it.port != 16'h0000)) counted++;
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready   <= 1'b0;
    end else if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    gate_report_t got;
    gate_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = gate_report_t'(out_tdata);
      if (gate_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = gate_q.pop_front();
        if (got.gate !== want.gate)
          report_mismatch($sformatf("gate %b, want %b", got.gate, want.gate));
        if (got.key !== want.key)
          report_mismatch($sformatf("key %0d, want %0d", got.key, want.key));
        if (got.vel !== want.vel)
          report_mismatch($sformatf("velocity %0d, want %0d", got.vel, want.vel));
        if (got.pitch !== want.pitch)
          report_mismatch($sformatf("pitch offset %h, want %h", got.pitch, want.pitch));
        if (got.eng !== want.eng)
          report_mismatch($sformatf("engine reset %b, want %b", got.eng, want.eng));
      end
    end
  end

  // no transaction on any channel for too long means the core has hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clear_note_table();
    note_order = '0;
    pitch_en   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_pitch_en(1'b1);
    for (int r = 0; r < DIR_ROWS; r++)
      send_item(dir_table[r].it, dir_table[r].has_want, dir_table[r].want);

    write_pitch_en(1'b0);
    run_random(88);

    write_pitch_en(1'b1);
    tx_idle_pct = 47;
    rx_idle_pct = 38;
    run_random(88);

    write_pitch_en(1'($urandom_range(1)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // long receiver hold-off with the sender still pushing, to back the core up
    rx_hold_req <= rx_hold_req + 1;
    run_random(4);
    wait_drained();
    run_random(84);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (gate_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", gate_q.size()));
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
